// ===== hw/rtl/priority_voice_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority voice allocator
// Concurrent checks sampled on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PVA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Types, constants and helpers shared by the voice allocator modules.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int ORIGIN_BITS  = 16;
  localparam int CHAN_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FIELD_CH_W   = 3;
  localparam int PRIO_W       = 8;
  localparam int CFG_W        = 4;
  localparam int OPCODE_W     = 2;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // register index, taken from the word address bit
  localparam logic REG_IDX_CHANNELS = 1'b0;
  localparam logic [CFG_W-1:0] CHANNELS_IN_USE_RESET = 4'd8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START       = 2'd0,
    OP_STOP_ORIGIN = 2'd1,
    OP_CH_FINISHED = 2'd2,
    OP_CLEAR_ALL   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ORIGIN,
    BK_ALLOC,
    BK_STEAL,
    BK_FINISH,
    BK_CLEAR
  } bk_state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic                  has_origin;
    logic [15:0]           origin_id;
    logic [7:0]            priority_req;
    logic [2:0]            channel_index;
  } pva_in_t;

  typedef struct packed {
    logic                  granted;
    logic [FIELD_CH_W-1:0] granted_channel;
    logic                  first_stop_valid;
    logic [FIELD_CH_W-1:0] first_stop_channel;
    logic                  second_stop_valid;
    logic [FIELD_CH_W-1:0] second_stop_channel;
  } pva_out_t;

  // classified command as it sits in the queue
  typedef struct packed {
    opcode_t               op;
    logic                  has_origin;
    logic [ORIGIN_BITS-1:0] origin;
    logic [PRIO_W-1:0]     prio;
    logic                  idx_ok;
    logic [CHAN_W-1:0]     chan;
  } pva_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pva_qstat_t;

  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] idx;
  } pva_pick_t;

  // lowest set bit of a channel vector
  function automatic pva_pick_t pick_first(input logic [MAX_CHANNELS-1:0] vec);
    pva_pick_t p;
    p = '0;
    for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
      if (vec[c]) begin
        p.found = 1'b1;
        p.idx   = CHAN_W'(c);
      end
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/priority_voice_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator_unit
// Sound-voice allocator with priority stealing over up to eight channels.
// Requests: a transaction is taken when start is high and busy is low; cmd
//   carries opcode, origin, priority and channel index. A front stage
//   classifies the request into a two-entry queue; busy is high only while
//   that queue is full.
// Results: one per request, on result for exactly one cycle with done high.
//   The receiver cannot stall, so nothing waits on the output side.
// Sequence, after acceptance: the back pops the command in idle, then a
//   start runs origin stop and allocate, adding steal when no free or
//   same-origin channel is found; stop runs origin stop only, and finish
//   and clear run their own state. The back takes a new command only after
//   it has emitted the last one; the queue holds requests meanwhile.
// Config: APB register channels_in_use at byte 0, written in the access
//   phase; pready is tied high. Write it only while no transaction is open.
// Reset (rst, synchronous): all channels free, queue empty, count = 8.
// ----------------------------------------------------------------------------
`include "priority_voice_allocator_unit_macros.svh"

module priority_voice_allocator_unit import pva_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  pva_in_t            cmd,
  // result channel
  output logic               done,
  output pva_out_t           result,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CFG_W-1:0] channels_in_use;
  logic             reg_hit;
  logic             cfg_wr;

  logic       push;
  pva_cmd_t   push_cmd;
  logic       pop;
  pva_cmd_t   pop_cmd;
  pva_qstat_t qstat;

  logic       second_match;

  // ---- configuration register ----
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_IDX_CHANNELS);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? {{(PDATA_W - CFG_W){1'b0}}, channels_in_use} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHANNELS_IN_USE_RESET;
    end else if (cfg_wr) begin
      channels_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // ---- front: accept and classify ----
  pva_front u_front (
    .start    (start),
    .cmd      (cmd),
    .qstat    (qstat),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // ---- decoupling queue ----
  pva_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .qstat    (qstat)
  );

  // ---- back: channel table and scan sequencer ----
  pva_back u_back (
    .clk             (clk),
    .rst             (rst),
    .channels_in_use (channels_in_use),
    .qstat           (qstat),
    .pop_cmd         (pop_cmd),
    .pop             (pop),
    .done            (done),
    .result          (result)
  );

  // ---- checks ----
  assign second_match = result.granted &&
                        (result.granted_channel == result.second_stop_channel);

  // every transaction passes through the pop state and at least one work state
  `PVA_ASSERT_NEXT(a_done_spacing, done, !done, "result strobes in adjacent cycles")
  // a channel stopped during allocation is always the one granted
  `PVA_ASSERT_SAME(a_second_stop_grant, done && result.second_stop_valid, second_match, "bad stop")
  // the back only pops what the queue holds
  `PVA_ASSERT_SAME(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")

endmodule

// ===== hw/rtl/pva_front.sv =====
// ----------------------------------------------------------------------------
// pva_front
// Accepts requests and classifies them into queue commands.
// ----------------------------------------------------------------------------
module pva_front import pva_pkg::*; (
  input  logic       start,
  input  pva_in_t    cmd,
  input  pva_qstat_t qstat,
  output logic       busy,
  output logic       push,
  output pva_cmd_t   push_cmd
);

  assign busy = qstat.full;
  assign push = start && !qstat.full;

  always_comb begin
    push_cmd.op         = opcode_t'(cmd.opcode);
    push_cmd.has_origin = cmd.has_origin;
    // absent origin is stored as zero
    push_cmd.origin     = cmd.has_origin ? ORIGIN_BITS'(cmd.origin_id) : '0;
    push_cmd.prio       = cmd.priority_req;
    push_cmd.idx_ok     = int'(cmd.channel_index) < MAX_CHANNELS;
    push_cmd.chan       = CHAN_W'(cmd.channel_index);
  end

endmodule

// ===== hw/rtl/pva_queue.sv =====
// ----------------------------------------------------------------------------
// pva_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module pva_queue import pva_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pva_cmd_t   push_cmd,
  input  logic       pop,
  output pva_cmd_t   pop_cmd,
  output pva_qstat_t qstat
);

  pva_cmd_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== hw/rtl/pva_back.sv =====
// ----------------------------------------------------------------------------
// pva_back
// Channel table and the sequencer that carries out queued commands.
// ----------------------------------------------------------------------------
module pva_back import pva_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] channels_in_use,
  input  pva_qstat_t       qstat,
  input  pva_cmd_t         pop_cmd,
  output logic             pop,
  output logic             done,
  output pva_out_t         result
);

  bk_state_t state, state_next;

  // channel table
  logic [MAX_CHANNELS-1:0] busy_vec;
  logic [MAX_CHANNELS-1:0] has_vec;
  logic [ORIGIN_BITS-1:0]  origin_arr [MAX_CHANNELS];
  logic [PRIO_W-1:0]       prio_arr   [MAX_CHANNELS];

  pva_cmd_t cur_cmd;
  pva_out_t res, res_next;

  logic [MAX_CHANNELS-1:0] act;
  logic [MAX_CHANNELS-1:0] org_hit;
  logic [MAX_CHANNELS-1:0] alloc_hit;
  logic [MAX_CHANNELS-1:0] steal_hit;
  pva_pick_t               org_pick, alloc_pick, steal_pick;

  logic              emit;
  logic              free_en, grant_en, clear_en;
  logic [CHAN_W-1:0] free_idx, grant_idx;

  // scan vectors; a count of zero still enables channel 0
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      act[c]       = (c == 0) || (int'(channels_in_use) > c);
      org_hit[c]   = act[c] && busy_vec[c] && (has_vec[c] == cur_cmd.has_origin) &&
                     (!cur_cmd.has_origin || origin_arr[c] == cur_cmd.origin);
      alloc_hit[c] = act[c] && (!busy_vec[c] || (cur_cmd.has_origin && has_vec[c] &&
                     origin_arr[c] == cur_cmd.origin));
      steal_hit[c] = act[c] && (prio_arr[c] >= cur_cmd.prio);
    end
    org_pick   = pick_first(org_hit);
    alloc_pick = pick_first(alloc_hit);
    steal_pick = pick_first(steal_hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    res_next   = res;
    free_en    = 1'b0;
    free_idx   = '0;
    grant_en   = 1'b0;
    grant_idx  = '0;
    clear_en   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop      = 1'b1;
          res_next = '0;
          case (pop_cmd.op)
            OP_START:       state_next = BK_ORIGIN;
            OP_STOP_ORIGIN: state_next = BK_ORIGIN;
            OP_CH_FINISHED: state_next = BK_FINISH;
            OP_CLEAR_ALL:   state_next = BK_CLEAR;
            default:        state_next = BK_IDLE;
          endcase
        end
      end
      BK_ORIGIN: begin
        if (org_pick.found) begin
          free_en                     = 1'b1;
          free_idx                    = org_pick.idx;
          res_next.first_stop_valid   = 1'b1;
          res_next.first_stop_channel = FIELD_CH_W'(org_pick.idx);
        end
        if (cur_cmd.op == OP_START) begin
          state_next = BK_ALLOC;
        end else begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      BK_ALLOC: begin
        if (alloc_pick.found) begin
          grant_en                 = 1'b1;
          grant_idx                = alloc_pick.idx;
          res_next.granted         = 1'b1;
          res_next.granted_channel = FIELD_CH_W'(alloc_pick.idx);
          // busy hit means same-origin reuse
          if (busy_vec[alloc_pick.idx]) begin
            res_next.second_stop_valid   = 1'b1;
            res_next.second_stop_channel = FIELD_CH_W'(alloc_pick.idx);
          end
          emit       = 1'b1;
          state_next = BK_IDLE;
        end else begin
          state_next = BK_STEAL;
        end
      end
      BK_STEAL: begin
        if (steal_pick.found) begin
          grant_en                     = 1'b1;
          grant_idx                    = steal_pick.idx;
          res_next.granted             = 1'b1;
          res_next.granted_channel     = FIELD_CH_W'(steal_pick.idx);
          res_next.second_stop_valid   = 1'b1;
          res_next.second_stop_channel = FIELD_CH_W'(steal_pick.idx);
        end
        emit       = 1'b1;
        state_next = BK_IDLE;
      end
      BK_FINISH: begin
        if (cur_cmd.idx_ok && busy_vec[cur_cmd.chan]) begin
          free_en                     = 1'b1;
          free_idx                    = cur_cmd.chan;
          res_next.first_stop_valid   = 1'b1;
          res_next.first_stop_channel = FIELD_CH_W'(cur_cmd.chan);
        end
        emit       = 1'b1;
        state_next = BK_IDLE;
      end
      BK_CLEAR: begin
        clear_en   = 1'b1;
        emit       = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_vec <= '0;
      has_vec  <= '0;
      done     <= 1'b0;
    end else begin
      done <= emit;
      if (clear_en) begin
        busy_vec <= '0;
        has_vec  <= '0;
      end
      if (free_en) begin
        busy_vec[free_idx] <= 1'b0;
        has_vec[free_idx]  <= 1'b0;
      end
      if (grant_en) begin
        busy_vec[grant_idx] <= 1'b1;
        has_vec[grant_idx]  <= cur_cmd.has_origin;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (pop)  cur_cmd <= pop_cmd;
    if (emit) result  <= res_next;
    if (grant_en) begin
      origin_arr[grant_idx] <= cur_cmd.origin;
      prio_arr[grant_idx]   <= cur_cmd.prio;
    end
  end

endmodule

// ===== tb/tb_priority_voice_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_voice_allocator_unit
// Self-checking bench for the priority voice allocator. A negedge driver
// feeds command transactions from a queue with random gaps. A posedge
// monitor checks every result against a channel-table predictor that is
// updated at each accepted transaction. The channel count register is
// rewritten over APB between drained phases, covering the extremes and the
// out-of-range values.
// ----------------------------------------------------------------------------
module tb_priority_voice_allocator_unit;
  import pva_pkg::*;

  localparam int RUN_LIMIT   = 300000;  // cycles before the run is declared hung
  localparam int SETTLE_CYC  = 8;       // quiet cycles after the last result
  localparam int GAP_MAX     = 9;       // longest idle gap between transactions
  localparam int PHASE_ITEMS = 180;     // random transactions per config phase
  localparam int NUM_PHASES  = 8;
  localparam logic [PADDR_W-1:0] ADDR_CHANNELS = 3'd0;  // channels_in_use

  // one queued command plus the idle time the driver spends before it
  typedef struct packed {
    pva_in_t    item;
    logic [3:0] gap;
    logic       drain;  // hold until every open transaction has completed
  } send_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  logic               busy;
  pva_in_t            cmd     = '0;
  logic               done;
  pva_out_t           result;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  priority_voice_allocator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted channel table and config copy
  // --------------------------------------------------------------------------
  logic              voice_busy    [MAX_CHANNELS];
  logic              voice_has_org [MAX_CHANNELS];
  logic [15:0]       voice_org     [MAX_CHANNELS];
  logic [PRIO_W-1:0] voice_prio    [MAX_CHANNELS];
  logic [CFG_W-1:0]  scan_cfg;

  send_t    send_q[$];    // commands waiting for the driver
  pva_out_t expect_q[$];  // predicted results, oldest first
  int       in_flight = 0;  // popped by the driver, result not yet seen
  int       err_cnt   = 0;
  int       cyc       = 0;
  int       gap_cnt   = 0;
  logic     took      = 1'b0;  // the last rising edge accepted a transaction

  function automatic void free_voice(input int ch);
    voice_busy[ch]    = 1'b0;
    voice_has_org[ch] = 1'b0;
    voice_org[ch]     = 16'h0000;
  endfunction

  // Applies one command to the table and returns the result it must produce.
  function automatic pva_out_t voice_predict(input pva_in_t c);
    pva_out_t    r;
    int          n;
    int          hit;
    int          sel;
    int          ch;
    logic [15:0] org;
    r = '0;
    // count of 0 scans one channel, anything past the built depth scans all
    n = (scan_cfg == 0) ? 1 : (scan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(scan_cfg);
    org = c.has_origin ? c.origin_id : 16'h0000;

    if (c.opcode == OP_START || c.opcode == OP_STOP_ORIGIN) begin
      // absent origin matches a busy channel that has no origin
      hit = -1;
      for (ch = 0; ch < n; ch++)
        if (hit < 0 && voice_busy[ch] && voice_has_org[ch] == c.has_origin &&
            (!c.has_origin || voice_org[ch] == org))
          hit = ch;
      if (hit >= 0) begin
        free_voice(hit);
        r.first_stop_valid   = 1'b1;
        r.first_stop_channel = 3'(hit);
      end
    end

    if (c.opcode == OP_START) begin
      // lowest free channel, or reuse of one with the same present origin
      sel = -1;
      for (ch = 0; ch < n; ch++)
        if (sel < 0) begin
          if (!voice_busy[ch]) begin
            sel = ch;
          end else if (c.has_origin && voice_has_org[ch] && voice_org[ch] == org) begin
            free_voice(ch);
            r.second_stop_valid   = 1'b1;
            r.second_stop_channel = 3'(ch);
            sel = ch;
          end
        end
      // steal the first channel that is no more important than the new sound
      if (sel < 0)
        for (ch = 0; ch < n; ch++)
          if (sel < 0 && voice_prio[ch] >= c.priority_req) begin
            free_voice(ch);
            r.second_stop_valid   = 1'b1;
            r.second_stop_channel = 3'(ch);
            sel = ch;
          end
      if (sel >= 0) begin
        voice_busy[sel]    = 1'b1;
        voice_has_org[sel] = c.has_origin;
        voice_org[sel]     = org;
        voice_prio[sel]    = c.priority_req;
        r.granted          = 1'b1;
        r.granted_channel  = 3'(sel);
      end
    end else if (c.opcode == OP_CH_FINISHED) begin
      // a 3-bit index never exceeds the built depth; a free channel is a no-op
      if (voice_busy[c.channel_index]) begin
        free_voice(int'(c.channel_index));
        r.first_stop_valid   = 1'b1;
        r.first_stop_channel = c.channel_index;
      end
    end else if (c.opcode == OP_CLEAR_ALL) begin
      // every built channel, scanned range or not
      for (ch = 0; ch < MAX_CHANNELS; ch++)
        free_voice(ch);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and predictor: sample on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pva_out_t want;
    cyc <= cyc + 1;
    if (cyc >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      took <= !rst && start && !busy;
      if (!rst && done) begin
        if (expect_q.size() == 0) begin
          $error("result with no transaction outstanding");
          err_cnt++;
        end else begin
          want = expect_q.pop_front();
          in_flight--;
          check_field("granted", 3'(want.granted), 3'(result.granted));
          check_field("granted_channel",     want.granted_channel,     result.granted_channel);
          check_field("first_stop_valid", 3'(want.first_stop_valid),
                      3'(result.first_stop_valid));
          check_field("first_stop_channel",  want.first_stop_channel,
                      result.first_stop_channel);
          check_field("second_stop_valid", 3'(want.second_stop_valid),
                      3'(result.second_stop_valid));
          check_field("second_stop_channel", want.second_stop_channel,
                      result.second_stop_channel);
        end
      end
      // predict in acceptance order; results come back in the same order
      if (!rst && start && !busy)
        expect_q.push_back(voice_predict(cmd));
    end
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // start stays high back to back when the next command has no gap.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      gap_cnt <= 0;
    end else if (!start || took) begin
      if (send_q.size() == 0 || (send_q[0].drain && in_flight != 0)) begin
        start <= 1'b0;
      end else if (gap_cnt < int'(send_q[0].gap)) begin
        start   <= 1'b0;
        gap_cnt <= gap_cnt + 1;
      end else begin
        cmd     <= send_q[0].item;
        start   <= 1'b1;
        gap_cnt <= 0;
        in_flight++;
        void'(send_q.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  logic burst = 1'b0;  // no idle gaps while set

  task automatic queue_cmd(input pva_in_t c, input logic drain);
    send_t s;
    s.item  = c;
    s.gap   = burst ? 4'd0 : 4'($urandom_range(0, GAP_MAX));
    s.drain = drain;
    send_q.push_back(s);
  endtask

  function automatic pva_in_t mk_cmd(input opcode_t op, input logic has, input logic [15:0] org,
                                     input logic [7:0] prio, input logic [2:0] idx);
    pva_in_t c;
    c.opcode        = op;
    c.has_origin    = has;
    c.origin_id     = org;
    c.priority_req  = prio;
    c.channel_index = idx;
    return c;
  endfunction

  // Origins mostly come from a small pool so that matches are frequent.
  function automatic pva_in_t voice_cmd_rand();
    pva_in_t c;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      c.opcode = OP_START;
    else if (pick < 70) c.opcode = OP_STOP_ORIGIN;
    else if (pick < 96) c.opcode = OP_CH_FINISHED;
    else                c.opcode = OP_CLEAR_ALL;
    c.has_origin = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 3) == 0) begin
      c.origin_id = 16'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0:       c.origin_id = 16'h0000;
        1:       c.origin_id = 16'hFFFF;
        2:       c.origin_id = 16'h0001;
        3:       c.origin_id = 16'h8000;
        4:       c.origin_id = 16'h5A5A;
        default: c.origin_id = 16'h00FF;
      endcase
    end
    // coarse priorities give plenty of ties for the at-least steal rule
    if ($urandom_range(0, 2) == 0) c.priority_req = 8'($urandom_range(0, 3) * 85);
    else                           c.priority_req = 8'($urandom);
    c.channel_index = 3'($urandom);
    return c;
  endfunction

  // Block the caller until the unit has nothing open, then let it settle.
  task automatic wait_idle();
    while (send_q.size() != 0 || in_flight != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_channels(input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CHANNELS;
    // upper bits are junk at times; only the low nibble is kept
    pwdata  <= PDATA_W'(val) | ($urandom_range(0, 1) ? ($urandom << CFG_W) : '0);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    scan_cfg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases per channel count
  // --------------------------------------------------------------------------
  initial begin
    int               drain_at;
    logic [CFG_W-1:0] cfg_val;

    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      free_voice(ch);
      voice_prio[ch] = '0;
    end
    scan_cfg = CHANNELS_IN_USE_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset count of eight
    queue_cmd(mk_cmd(OP_START, 1'b0, 16'h1234, 8'd128, 3'd0), 1'b0);
    // second origin-less sound replaces the first
    queue_cmd(mk_cmd(OP_START, 1'b0, 16'hFFFF, 8'd64, 3'd7), 1'b0);
    for (int k = 1; k < MAX_CHANNELS; k++)
      queue_cmd(mk_cmd(OP_START, 1'b1, 16'(k), 8'd200, 3'(k)), 1'b0);
    // table full, nothing unimportant enough: refused
    queue_cmd(mk_cmd(OP_START, 1'b1, 16'hFFFF, 8'd255, 3'd0), 1'b0);
    // equal priority is enough to steal
    queue_cmd(mk_cmd(OP_START, 1'b1, 16'hFFFF, 8'd200, 3'd0), 1'b0);
    queue_cmd(mk_cmd(OP_START, 1'b1, 16'h0000, 8'd0, 3'd0), 1'b0);
    // same origin already playing: stopped and reused
    queue_cmd(mk_cmd(OP_START, 1'b1, 16'h0003, 8'd255, 3'd0), 1'b0);
    queue_cmd(mk_cmd(OP_STOP_ORIGIN, 1'b1, 16'h0005, 8'd0, 3'd0), 1'b0);
    // absent origin must not match a present origin of zero
    queue_cmd(mk_cmd(OP_STOP_ORIGIN, 1'b0, 16'h0000, 8'd255, 3'd7), 1'b0);
    queue_cmd(mk_cmd(OP_STOP_ORIGIN, 1'b1, 16'h0000, 8'd0, 3'd0), 1'b0);
    // finished on a free channel, then on the top channel
    queue_cmd(mk_cmd(OP_CH_FINISHED, 1'b0, 16'h0000, 8'd0, 3'd5), 1'b0);
    queue_cmd(mk_cmd(OP_CH_FINISHED, 1'b1, 16'hFFFF, 8'd255, 3'd7), 1'b0);
    queue_cmd(mk_cmd(OP_CLEAR_ALL, 1'b1, 16'hFFFF, 8'd255, 3'd7), 1'b0);
    queue_cmd(mk_cmd(OP_START, 1'b1, 16'hABCD, 8'd0, 3'd0), 1'b0);
    queue_cmd(mk_cmd(OP_CH_FINISHED, 1'b0, 16'h0000, 8'd0, 3'd0), 1'b0);
    queue_cmd(mk_cmd(OP_STOP_ORIGIN, 1'b0, 16'hFFFF, 8'd0, 3'd0), 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       cfg_val = 4'd1;
        1:       cfg_val = 4'd0;   // acts as one
        2:       cfg_val = 4'd15;  // acts as the built depth
        3:       cfg_val = 4'd8;
        4:       cfg_val = 4'd2;
        default: cfg_val = 4'($urandom_range(0, 15));
      endcase
      write_channels(cfg_val);
      // one mid-phase pause until every open transaction completes
      drain_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        queue_cmd(voice_cmd_rand(), k == drain_at);
      end
    end

    wait_idle();
    if (expect_q.size() != 0) begin
      $error("%0d expected results never arrived", expect_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
